// ===== hw/rtl/rff_pkg.sv =====
package rff_pkg;

    localparam int CW   = 21;
    localparam int DW   = 32;
    localparam int CFGW = 63;
    localparam int XW   = 36;
    localparam int TW   = 42;
    localparam int GW   = 46;
    localparam int RPW  = 53;
    localparam int CPW  = 57;
    localparam int WPW  = 63;
    localparam int MPW  = 63;
    localparam int HW   = 16;

    localparam int unsigned ROT_SH  = 18;
    localparam int unsigned CRS_SH  = 12;
    localparam int unsigned CRS2_SH = 11;
    localparam int unsigned MAS_SH  = 16;
    localparam int unsigned LA_SH   = 4;

    localparam int IDXW = 3;
    localparam logic [IDXW-1:0] REG_ROT_ROW0 = 3'd0;
    localparam logic [IDXW-1:0] REG_ROT_ROW1 = 3'd1;
    localparam logic [IDXW-1:0] REG_ROT_ROW2 = 3'd2;
    localparam logic [IDXW-1:0] REG_ANG_VEL  = 3'd3;
    localparam logic [IDXW-1:0] REG_ANG_ACC  = 3'd4;
    localparam logic [IDXW-1:0] REG_LIN_ACC  = 3'd5;

    localparam logic [CFGW-1:0] RST_ROT_ROW0 = 63'd262144;
    localparam logic [CFGW-1:0] RST_ROT_ROW1 = 63'd549755813888;
    localparam logic [CFGW-1:0] RST_ROT_ROW2 = 63'd1152921504606846976;

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (TW - 1)) - 64'sd1;
    localparam logic signed [63:0] LIM_LO = -(64'sd1 <<< (TW - 1));
    localparam logic signed [DW-1:0] F_MAX = 32'sh7fffffff;
    localparam logic signed [DW-1:0] F_MIN = 32'sh80000000;

    typedef logic signed [CW-1:0] t_coef;
    typedef t_coef t_cvec [3];
    typedef t_cvec t_mat [3];
    typedef logic signed [DW-1:0] t_ivec [3];
    typedef logic signed [XW-1:0] t_xvec [3];
    typedef logic signed [TW-1:0] t_svec [3];

    typedef struct packed {
        logic vld;
        logic last;
    } t_ctl;

    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v,
                                                 input int unsigned sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [TW-1:0] f_clip(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > LIM_HI) begin
            c = LIM_HI;
        end else if (v < LIM_LO) begin
            c = LIM_LO;
        end
        return c[TW-1:0];
    endfunction

endpackage

// ===== hw/rtl/rff_in_if.sv =====
interface rff_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] point_mass;
    logic               last_in;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, point_mass, last_in,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, point_mass, last_in,
        output ready
    );
endinterface

// ===== hw/rtl/rff_out_if.sv =====
interface rff_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               saturated;
    logic               last_out;

    modport source (
        output valid, force_x, force_y, force_z, saturated, last_out,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, force_z, saturated, last_out,
        output ready
    );
endinterface

// ===== hw/rtl/rff_rotate.sv =====
module rff_rotate (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  rff_pkg::t_ctl          i_ctl,
    input  rff_pkg::t_ivec         i_pos,
    input  rff_pkg::t_ivec         i_vel,
    input  logic [rff_pkg::DW-1:0] i_mass,
    input  rff_pkg::t_mat          i_rot,
    output rff_pkg::t_ctl          o_ctl,
    output rff_pkg::t_xvec         o_xo,
    output rff_pkg::t_xvec         o_vo,
    output logic [rff_pkg::DW-1:0] o_mass
);
    import rff_pkg::*;

    t_ctl                  r_ctl [2];
    logic [DW-1:0]         r_mass [2];
    logic signed [RPW-1:0] r_px [3][3];
    logic signed [RPW-1:0] r_pv [3][3];
    t_xvec                 r_xo;
    t_xvec                 r_vo;
    t_xvec                 n_xo;
    t_xvec                 n_vo;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_xo[i] = XW'(f_rnd(64'(r_px[i][0]) + 64'(r_px[i][1]) + 64'(r_px[i][2]),
                                ROT_SH));
            n_vo[i] = XW'(f_rnd(64'(r_pv[i][0]) + 64'(r_pv[i][1]) + 64'(r_pv[i][2]),
                                ROT_SH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
            r_ctl[1] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            r_ctl[1] <= r_ctl[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mass[0] <= i_mass;
            r_mass[1] <= r_mass[0];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_px[i][j] <= i_rot[i][j] * i_pos[j];
                    r_pv[i][j] <= i_rot[i][j] * i_vel[j];
                end
            end
            r_xo <= n_xo;
            r_vo <= n_vo;
        end
    end

    assign o_ctl  = r_ctl[1];
    assign o_mass = r_mass[1];
    assign o_xo   = r_xo;
    assign o_vo   = r_vo;

endmodule

// ===== hw/rtl/rff_accel.sv =====
module rff_accel (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  rff_pkg::t_ctl          i_ctl,
    input  rff_pkg::t_xvec         i_xo,
    input  rff_pkg::t_xvec         i_vo,
    input  logic [rff_pkg::DW-1:0] i_mass,
    input  rff_pkg::t_cvec         i_om,
    input  rff_pkg::t_cvec         i_al,
    input  rff_pkg::t_cvec         i_la,
    output rff_pkg::t_ctl          o_ctl,
    output rff_pkg::t_svec         o_sum,
    output logic [rff_pkg::DW-1:0] o_mass
);
    import rff_pkg::*;

    localparam int NST = 5;

    t_ctl                  r_ctl [NST];
    logic [DW-1:0]         r_mass [NST];
    logic signed [CPW-1:0] r_pa [3][2];
    logic signed [CPW-1:0] r_pw [3][2];
    logic signed [CPW-1:0] r_pc [3][2];
    t_svec                 r_t1_d;
    t_svec                 r_w1_d;
    t_svec                 r_t3_d;
    logic signed [WPW-1:0] r_pq [3][2];
    t_svec                 r_t1_e;
    t_svec                 r_t3_e;
    t_svec                 r_t1_f;
    t_svec                 r_t2_f;
    t_svec                 r_t3_f;
    t_svec                 r_sum;
    t_svec                 n_t1;
    t_svec                 n_w1;
    t_svec                 n_t3;
    t_svec                 n_t2;
    t_svec                 n_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t1[i]  = f_clip(f_rnd(64'(r_pa[i][0]) - 64'(r_pa[i][1]), CRS_SH));
            n_w1[i]  = f_clip(f_rnd(64'(r_pw[i][0]) - 64'(r_pw[i][1]), CRS_SH));
            n_t3[i]  = f_clip(f_rnd(64'(r_pc[i][0]) - 64'(r_pc[i][1]), CRS2_SH));
            n_t2[i]  = f_clip(f_rnd(64'(r_pq[i][0]) - 64'(r_pq[i][1]), CRS_SH));
            n_sum[i] = f_clip(64'(r_t1_f[i]) + 64'(r_t2_f[i]) + 64'(r_t3_f[i])
                              + (64'(i_la[i]) <<< LA_SH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < NST; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mass[0] <= i_mass;
            for (int k = 1; k < NST; k++) begin
                r_mass[k] <= r_mass[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_pa[i][0] <= i_al[NXT[i]] * i_xo[PRV[i]];
                r_pa[i][1] <= i_al[PRV[i]] * i_xo[NXT[i]];
                r_pw[i][0] <= i_om[NXT[i]] * i_xo[PRV[i]];
                r_pw[i][1] <= i_om[PRV[i]] * i_xo[NXT[i]];
                r_pc[i][0] <= i_om[NXT[i]] * i_vo[PRV[i]];
                r_pc[i][1] <= i_om[PRV[i]] * i_vo[NXT[i]];
                r_pq[i][0] <= i_om[NXT[i]] * r_w1_d[PRV[i]];
                r_pq[i][1] <= i_om[PRV[i]] * r_w1_d[NXT[i]];
            end
            r_t1_d <= n_t1;
            r_w1_d <= n_w1;
            r_t3_d <= n_t3;
            r_t1_e <= r_t1_d;
            r_t3_e <= r_t3_d;
            r_t1_f <= r_t1_e;
            r_t2_f <= n_t2;
            r_t3_f <= r_t3_e;
            r_sum  <= n_sum;
        end
    end

    assign o_ctl  = r_ctl[NST-1];
    assign o_mass = r_mass[NST-1];
    assign o_sum  = r_sum;

endmodule

// ===== hw/rtl/rff_force.sv =====
module rff_force (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  rff_pkg::t_ctl                i_ctl,
    input  rff_pkg::t_svec               i_sum,
    input  logic [rff_pkg::DW-1:0]       i_mass,
    input  rff_pkg::t_mat                i_rot,
    output rff_pkg::t_ctl                o_ctl,
    output rff_pkg::t_ivec               o_force,
    output logic                         o_sat
);
    import rff_pkg::*;

    localparam int NST = 4;

    t_ctl                  r_ctl [NST];
    logic [DW-1:0]         r_mass [NST-2];
    logic signed [WPW-1:0] r_pr [3][3];
    logic signed [GW-1:0]  r_g [3];
    logic signed [MPW-1:0] r_ph [3];
    logic signed [MPW-1:0] r_pl [3];
    t_ivec                 r_force;
    logic                  r_sat;
    logic signed [GW-1:0]  n_g [3];
    t_ivec                 n_force;
    logic                  n_sat;
    logic signed [63:0]    w_f [3];

    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_g[i] = GW'(f_rnd(64'(r_pr[i][0]) + 64'(r_pr[i][1]) + 64'(r_pr[i][2]),
                               ROT_SH));
            w_f[i] = -(64'(r_ph[i]) + f_rnd(64'(r_pl[i]), MAS_SH));
            n_force[i] = w_f[i][DW-1:0];
            if (w_f[i] > 64'(F_MAX)) begin
                n_force[i] = F_MAX;
                n_sat      = 1'b1;
            end else if (w_f[i] < 64'(F_MIN)) begin
                n_force[i] = F_MIN;
                n_sat      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < NST; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mass[0] <= i_mass;
            r_mass[1] <= r_mass[0];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[i][j] <= i_rot[j][i] * i_sum[j];
                end
                r_ph[i] <= $signed({1'b0, r_mass[1][DW-1:HW]}) * r_g[i];
                r_pl[i] <= $signed({1'b0, r_mass[1][HW-1:0]}) * r_g[i];
            end
            r_g     <= n_g;
            r_force <= n_force;
            r_sat   <= n_sat;
        end
    end

    assign o_ctl   = r_ctl[NST-1];
    assign o_force = r_force;
    assign o_sat   = r_sat;

endmodule

// ===== hw/rtl/rotating_frame_inertial_force.sv =====
// Channel  Direction  Handshake         Payload
// i_in     input      valid / ready     pos_x..z, vel_x..z, point_mass, last_in
// o_out    output     valid / ready     force_x..z, saturated, last_out
// i_cfg    input      i_cfg_we          i_cfg_idx, i_cfg_data (63 bits)
//
// One transfer per cycle is accepted while o_out is not stalled.
// Each point runs through rotation, cross products, transposed rotation and mass
// scaling, each split into product and sum stages.
// Reset clears all valid bits and loads the identity rotation and zero vectors.
// A stall on o_out freezes every stage, and i_in.ready drops in the same cycle.
module rotating_frame_inertial_force (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [rff_pkg::IDXW-1:0] i_cfg_idx,
    input  logic [rff_pkg::CFGW-1:0] i_cfg_data,
    rff_in_if.sink                   i_in,
    rff_out_if.source                o_out
);
    import rff_pkg::*;

    logic [CFGW-1:0] r_rot [3];
    logic [CFGW-1:0] r_om;
    logic [CFGW-1:0] r_al;
    logic [CFGW-1:0] r_la;

    t_mat           w_rot;
    t_cvec          w_om;
    t_cvec          w_al;
    t_cvec          w_la;
    logic           w_en;
    t_ctl           w_ctl_in;
    t_ivec          w_pos;
    t_ivec          w_vel;
    t_ctl           w_ctl_rot;
    t_xvec          w_xo;
    t_xvec          w_vo;
    logic [DW-1:0]  w_mass_rot;
    t_ctl           w_ctl_acc;
    t_svec          w_sum;
    logic [DW-1:0]  w_mass_acc;
    t_ctl           w_ctl_out;
    t_ivec          w_force;
    logic           w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= RST_ROT_ROW0;
            r_rot[1] <= RST_ROT_ROW1;
            r_rot[2] <= RST_ROT_ROW2;
            r_om     <= '0;
            r_al     <= '0;
            r_la     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROT_ROW0: r_rot[0] <= i_cfg_data;
                REG_ROT_ROW1: r_rot[1] <= i_cfg_data;
                REG_ROT_ROW2: r_rot[2] <= i_cfg_data;
                REG_ANG_VEL:  r_om     <= i_cfg_data;
                REG_ANG_ACC:  r_al     <= i_cfg_data;
                REG_LIN_ACC:  r_la     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_rot[i][j] = r_rot[i][CW*j +: CW];
            end
            w_om[i] = r_om[CW*i +: CW];
            w_al[i] = r_al[CW*i +: CW];
            w_la[i] = r_la[CW*i +: CW];
        end
    end

    assign w_en          = !o_out.valid || o_out.ready;
    assign i_in.ready    = w_en;
    assign w_ctl_in.vld  = i_in.valid;
    assign w_ctl_in.last = i_in.last_in;
    assign w_pos[0]      = i_in.pos_x;
    assign w_pos[1]      = i_in.pos_y;
    assign w_pos[2]      = i_in.pos_z;
    assign w_vel[0]      = i_in.vel_x;
    assign w_vel[1]      = i_in.vel_y;
    assign w_vel[2]      = i_in.vel_z;

    rff_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl_in),
        .i_pos   (w_pos),
        .i_vel   (w_vel),
        .i_mass  (i_in.point_mass),
        .i_rot   (w_rot),
        .o_ctl   (w_ctl_rot),
        .o_xo    (w_xo),
        .o_vo    (w_vo),
        .o_mass  (w_mass_rot)
    );

    rff_accel u_accel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl_rot),
        .i_xo    (w_xo),
        .i_vo    (w_vo),
        .i_mass  (w_mass_rot),
        .i_om    (w_om),
        .i_al    (w_al),
        .i_la    (w_la),
        .o_ctl   (w_ctl_acc),
        .o_sum   (w_sum),
        .o_mass  (w_mass_acc)
    );

    rff_force u_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl_acc),
        .i_sum   (w_sum),
        .i_mass  (w_mass_acc),
        .i_rot   (w_rot),
        .o_ctl   (w_ctl_out),
        .o_force (w_force),
        .o_sat   (w_sat)
    );

    assign o_out.valid     = w_ctl_out.vld;
    assign o_out.last_out  = w_ctl_out.last;
    assign o_out.force_x   = w_force[0];
    assign o_out.force_y   = w_force[1];
    assign o_out.force_z   = w_force[2];
    assign o_out.saturated = w_sat;

endmodule

// ===== hw/rtl/rff_check.sv =====
module rff_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_ready,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [rff_pkg::DW-1:0] i_force_x,
    input  logic signed [rff_pkg::DW-1:0] i_force_y,
    input  logic signed [rff_pkg::DW-1:0] i_force_z,
    input  logic                       i_saturated,
    input  logic                       i_last_out
);
    import rff_pkg::*;

    // A result that waits is neither dropped nor changed.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_force_x) && $stable(i_force_y)
            && $stable(i_force_z) && $stable(i_saturated) && $stable(i_last_out))
        else $error("result changed while stalled");

    // A stalled output freezes the whole pipeline, so no new point may enter.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted while the pipeline is frozen");

    // The saturation flag means at least one component sits on a rail.
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> i_force_x == F_MAX || i_force_x == F_MIN
            || i_force_y == F_MAX || i_force_y == F_MIN
            || i_force_z == F_MAX || i_force_z == F_MIN)
        else $error("saturation flag without a clipped component");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind rotating_frame_inertial_force rff_check u_rff_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_force_x   (o_out.force_x),
    .i_force_y   (o_out.force_y),
    .i_force_z   (o_out.force_z),
    .i_saturated (o_out.saturated),
    .i_last_out  (o_out.last_out)
);
